// ===== sv/mkd_pkg.sv =====
// mkd_pkg: word types and fixed constants for the morse key decoder
// no dependencies; imported by morse_key_decoder

package mkd_pkg;

  localparam int PATTERN_BITS = 8;
  localparam int LENGTH_BITS  = 4;
  localparam int TICK_BITS    = 16;
  localparam logic [TICK_BITS-1:0] DAH_TICKS_RESET = 16'd200;

  typedef enum logic [0:0] {
    PURPOSE_DAH = 1'b0,
    PURPOSE_GAP = 1'b1
  } timer_purpose_t;

  typedef struct packed {
    logic key_pressed;
    logic key_released;
  } in_word_t;

  typedef struct packed {
    logic                    char_valid;
    logic [LENGTH_BITS-1:0]  char_length;
    logic [PATTERN_BITS-1:0] char_pattern;
    logic                    tone_on;
  } out_word_t;

endpackage

// ===== sv/morse_key_decoder.sv =====
// morse_key_decoder: decodes key press/release ticks into morse characters
// depends on mkd_pkg for the word types and constants
//
// usage:
//   in channel (in_valid/in_ready/in_data): one word per timer tick carrying
//   the key press and key release flags of that tick.
//   out channel (out_valid/out_ready/out_data): exactly one word per input
//   word: the finished character (valid, length, dah pattern) if the gap
//   timer ran out on that tick, and the sidetone flag after the tick.
//   cfg_write_en/cfg_write_data set dah_ticks, the dah length and character
//   gap in ticks; write it only while the block is idle.
// timing:
//   an accepted word goes to the output register (to the skid stage on a
//   stall); one word per cycle is sustained while out_ready is high, the
//   state update being a single pass of flag, compare and 16-bit decrement
//   logic between the state registers and the output register.
// reset (rst, synchronous): timer idle, buffer empty, tone off,
//   dah_ticks back to 200, both output stages empty.
// stall: the output register is backed by a one-word skid stage, so one more
//   word is taken while out_ready is low; in_ready drops only while the skid
//   stage is full.

module morse_key_decoder
  import mkd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [TICK_BITS-1:0] cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

  logic [TICK_BITS-1:0]    dah_ticks;
  logic [CNT_W-1:0]        element_count, element_count_next;
  logic [PATTERN_BITS-1:0] pattern_buffer, pattern_buffer_next;
  timer_purpose_t          timer_purpose, timer_purpose_next;
  logic [TICK_BITS-1:0]    timer_remaining, timer_remaining_next;
  logic                    tone_active, tone_active_next;

  out_word_t result;
  out_word_t skid_data;
  logic      skid_valid;
  logic      accept;
  logic      expired;
  logic      gap_emit;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  // one tick of the key decoder
  always_comb begin
    element_count_next   = element_count;
    pattern_buffer_next  = pattern_buffer;
    timer_purpose_next   = timer_purpose;
    timer_remaining_next = timer_remaining;
    tone_active_next     = tone_active;
    result               = '0;
    expired              = 1'b0;
    gap_emit             = 1'b0;

    if (timer_remaining != '0) begin
      timer_remaining_next = timer_remaining - 1'b1;
      expired = (timer_remaining == TICK_BITS'(1));
    end
    gap_emit = expired && (timer_purpose == PURPOSE_GAP) && (element_count != '0);

    if (gap_emit) begin
      result.char_valid   = 1'b1;
      result.char_length  = LENGTH_BITS'(element_count);
      result.char_pattern = pattern_buffer;
      result.tone_on      = tone_active;
      element_count_next  = '0;
      pattern_buffer_next = '0;
    end else begin
      if (expired && (timer_purpose == PURPOSE_DAH) && (element_count < CNT_MAX)
          && (32'(element_count) < 32'(PATTERN_BITS))) begin
        pattern_buffer_next = pattern_buffer | (PATTERN_BITS'(1) << element_count);
      end
      if (in_data.key_pressed) begin
        tone_active_next     = 1'b1;
        timer_purpose_next   = PURPOSE_DAH;
        timer_remaining_next = dah_ticks;
      end
      // release only counts while the tone is on (after a same-tick press too)
      if (in_data.key_released && tone_active_next) begin
        tone_active_next = 1'b0;
        if (element_count < CNT_MAX) begin
          element_count_next = element_count + 1'b1;
        end
        timer_purpose_next   = PURPOSE_GAP;
        timer_remaining_next = dah_ticks;
      end
      result.tone_on = tone_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dah_ticks       <= DAH_TICKS_RESET;
      element_count   <= '0;
      pattern_buffer  <= '0;
      timer_purpose   <= PURPOSE_DAH;
      timer_remaining <= '0;
      tone_active     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        dah_ticks <= cfg_write_data;
      end
      if (accept) begin
        element_count   <= element_count_next;
        pattern_buffer  <= pattern_buffer_next;
        timer_purpose   <= timer_purpose_next;
        timer_remaining <= timer_remaining_next;
        tone_active     <= tone_active_next;
      end
    end
  end

  // output register with one-word skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a word while the output register is empty");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_MAX)
    else $error("element count above its limit");

  a_empty_out_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && !out_valid) |=> out_valid)
    else $error("accepted word did not reach the output register");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && gap_emit) |=> (element_count == '0) && (pattern_buffer == '0))
    else $error("buffer not cleared after a character was reported");

endmodule

// ===== test/morse_key_decoder_test.sv =====
`timescale 1ns / 1ps
// morse_key_decoder_test: self-checking testbench for morse_key_decoder
// keys press/release ticks into the block and checks every output word against
// a cycle-free decoder model kept here; depends on mkd_pkg and morse_key_decoder

module morse_key_decoder_test
  import mkd_pkg::*;
();

  localparam int MAX_ELEMENTS = 8;
  localparam int CYCLE_LIMIT  = 300000;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [TICK_BITS-1:0] cfg_write_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_word_t            out_data;

  // decoder model state
  logic [TICK_BITS-1:0]    dah_len    = DAH_TICKS_RESET;
  logic [LENGTH_BITS-1:0]  elem_count = '0;
  logic [PATTERN_BITS-1:0] dah_bits   = '0;
  timer_purpose_t          wait_kind  = PURPOSE_DAH;
  logic [TICK_BITS-1:0]    ticks_left = '0;
  logic                    tone       = 1'b0;

  out_word_t expected_ticks[$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  int        words_sent  = 0;
  int        hold_cycles = 0;
  bit        source_gaps = 1'b0;
  bit        sink_stalls = 1'b0;

  morse_key_decoder #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one tick of the decoder: expiry first, then press, then release
  function automatic out_word_t decode_tick(in_word_t w);
    out_word_t r;
    logic      expired;
    r = '0;
    expired = 1'b0;
    if (ticks_left != 0) begin
      ticks_left = ticks_left - 1'b1;
      expired = (ticks_left == 0);
    end
    if (expired && wait_kind == PURPOSE_DAH) begin
      if (elem_count < MAX_ELEMENTS) dah_bits[elem_count[2:0]] = 1'b1;
    end else if (expired && elem_count != 0) begin
      // character done, key flags of this tick are dropped
      r.char_valid   = 1'b1;
      r.char_length  = elem_count;
      r.char_pattern = dah_bits;
      r.tone_on      = tone;
      elem_count = '0;
      dah_bits   = '0;
      return r;
    end
    if (w.key_pressed) begin
      tone       = 1'b1;
      wait_kind  = PURPOSE_DAH;
      ticks_left = dah_len;
    end
    if (w.key_released && tone) begin
      tone = 1'b0;
      if (elem_count < MAX_ELEMENTS) elem_count = elem_count + 1'b1;
      wait_kind  = PURPOSE_GAP;
      ticks_left = dah_len;
    end
    r.tone_on = tone;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("output word with nothing expected: %h", out_data);
        fail_count = fail_count + 1;
      end else begin
        want = expected_ticks.pop_front();
        if (out_data.char_valid !== want.char_valid) begin
          $error("char_valid: expected %0d, got %0d", want.char_valid, out_data.char_valid);
          fail_count = fail_count + 1;
        end
        if (out_data.char_length !== want.char_length) begin
          $error("char_length: expected %0d, got %0d", want.char_length,
                 out_data.char_length);
          fail_count = fail_count + 1;
        end
        if (out_data.char_pattern !== want.char_pattern) begin
          $error("char_pattern: expected %h, got %h", want.char_pattern,
                 out_data.char_pattern);
          fail_count = fail_count + 1;
        end
        if (out_data.tone_on !== want.tone_on) begin
          $error("tone_on: expected %0d, got %0d", want.tone_on, out_data.tone_on);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // receiver: long hold on request, short random stalls otherwise
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(in_word_t w);
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_ticks.push_back(decode_tick(w));
    words_sent++;
  endtask

  task automatic send_flags(bit pressed, bit released);
    in_word_t w;
    w.key_pressed  = pressed;
    w.key_released = released;
    send_word(w);
  endtask

  task automatic send_idle(int n);
    repeat (n) send_flags(1'b0, 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_ticks.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_dah_ticks(logic [TICK_BITS-1:0] value);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    dah_len = value;
  endtask

  task automatic test_directed_keying();
    write_dah_ticks(16'd2);
    send_flags(1'b0, 1'b1);  // release with tone off is ignored
    send_flags(1'b1, 1'b0);
    send_flags(1'b1, 1'b0);  // press while tone on restarts the dah wait
    send_idle(1);
    send_flags(1'b0, 1'b1);  // dah expiry and release in one tick
    send_flags(1'b1, 1'b1);  // press and release together
    send_idle(1);
    send_flags(1'b1, 1'b1);  // gap expiry swallows the key flags
    // zero dah_ticks: timer never runs
    write_dah_ticks(16'd0);
    send_flags(1'b1, 1'b0);
    send_idle(2);
    send_flags(1'b0, 1'b1);
    send_idle(1);
    // shortest timer, element appended to the pending character
    write_dah_ticks(16'd1);
    send_flags(1'b1, 1'b0);
    send_idle(1);
    send_flags(1'b0, 1'b1);
    send_idle(1);
    // longest timer is loaded, then overridden by a reload at a short setting
    write_dah_ticks(16'hffff);
    send_flags(1'b1, 1'b0);
    send_flags(1'b0, 1'b1);
    write_dah_ticks(16'd3);
    send_flags(1'b1, 1'b1);
    send_idle(3);
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 40;
    repeat (16) send_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // mostly well-formed characters with random element timing, some noise
  task automatic test_random_keying(int n_words);
    int target;
    int span;
    int mode;
    int n_el;
    bit long_press;
    target = words_sent + n_words;
    span = (dah_len == 0) ? 4 : int'(dah_len);
    while (words_sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        mode = $urandom_range(0, 2);  // mixed, all dits, all dahs
        n_el = $urandom_range(1, 10);
        for (int e = 0; e < n_el; e++) begin
          long_press = (mode == 2) || (mode == 0 && $urandom_range(0, 1) == 1);
          if (!long_press && $urandom_range(0, 3) == 0) begin
            send_flags(1'b1, 1'b1);
          end else begin
            send_flags(1'b1, 1'b0);
            if (long_press) send_idle($urandom_range(span - 1, span + 2));
            else send_idle($urandom_range(0, (span >= 2) ? span - 2 : 0));
            send_flags(1'b0, 1'b1);
          end
          if (e != n_el - 1) send_idle($urandom_range(0, (span >= 2) ? span - 2 : 0));
        end
        send_idle(span + $urandom_range(0, 3));
      end else begin
        repeat ($urandom_range(1, 6))
          send_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_keying();
    test_output_backpressure();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    write_dah_ticks(16'd1);
    test_random_keying(200);
    write_dah_ticks(16'd2);
    test_random_keying(250);
    write_dah_ticks(16'($urandom_range(3, 6)));
    test_random_keying(250);
    write_dah_ticks(16'($urandom_range(7, 12)));
    test_random_keying(250);
    write_dah_ticks(16'd0);
    test_random_keying(60);
    // closing stretch at full rate
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    write_dah_ticks(16'd4);
    test_random_keying(150);
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
